// File: rtl/core/htbd_pkg.sv
// types and constants shared by the huffman tree byte decoder
package htbd_pkg;

  // item kinds
  localparam logic [1:0] KIND_LOAD  = 2'd0;
  localparam logic [1:0] KIND_DATA  = 2'd1;
  localparam logic [1:0] KIND_START = 2'd2;

  localparam int BITS_PER_BYTE = 8;

  typedef struct packed {
    logic [1:0] kind;
    logic [7:0] compressed_byte;
    logic [7:0] node_index;
    logic [7:0] zero_child_value;
    logic       zero_child_is_node;
    logic [7:0] one_child_value;
    logic       one_child_is_node;
  } item_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       run_last;
    logic       stream_end;
  } result_t;

  // one child link, flag above value
  typedef struct packed {
    logic       is_node;
    logic [7:0] value;
  } child_t;

  // stored node, bit-one child in the upper half
  typedef struct packed {
    child_t one;
    child_t zero;
  } node_t;

  typedef enum logic {
    ST_IDLE,
    ST_WALK
  } state_t;

endpackage

// File: rtl/core/huffman_tree_byte_decoder.sv
// top level of the huffman tree byte decoder
// load and start items are taken in idle and leave the block idle; kind 3 is accepted and dropped
// a data byte is accepted, then walked one node per decoded bit (up to 8), then
// closed by flushing the held result; the walk waits while the result side stalls
// each bit needs one dependent read of the node table through its single read port
// synchronous reset puts the walk at the root with count, end flag and length at zero;
// the node table is not cleared and holds garbage until loaded
module huffman_tree_byte_decoder import htbd_pkg::*; #(
  parameter int NODE_COUNT  = 255,
  parameter int LENGTH_BITS = 24
) (
  input  logic                   clk,
  input  logic                   rst,
  // item channel
  input  logic                   item_valid,
  output logic                   item_stall,
  input  item_t                  item,
  // result channel
  output logic                   result_valid,
  input  logic                   result_stall,
  output result_t                result,
  // output_length register write
  input  logic                   cfg_valid,
  output logic                   cfg_ready,
  input  logic [LENGTH_BITS-1:0] cfg_data
);

  localparam int ADDR_W = $clog2(NODE_COUNT);
  localparam logic [7:0] ROOT = 8'(NODE_COUNT - 1);

  state_t                 state, state_next;
  logic [7:0]             current_node, current_node_next;
  logic [LENGTH_BITS-1:0] bytes_produced, bytes_produced_next;
  logic [LENGTH_BITS-1:0] bytes_inc;
  logic                   stream_finished, stream_finished_next;
  logic [3:0]             bit_cnt, bit_cnt_next;
  logic [7:0]             data_byte;
  logic [LENGTH_BITS-1:0] output_length;

  // pending result: held until we know whether it ends this byte's run
  logic    pend_valid, pend_valid_next;
  result_t pend, pend_next;

  logic    out_load;
  result_t out_load_data;
  logic    out_free;

  logic    item_acc;
  logic    data_load;
  logic    mem_we;
  node_t   node_rd;
  child_t  child;
  logic    path;
  logic    stop;

  assign item_stall = (state != ST_IDLE);
  assign item_acc   = item_valid && !item_stall;
  assign cfg_ready  = 1'b1;
  assign out_free   = !result_valid || !result_stall;

  // node table; read address follows the node the walk holds next cycle
  htbd_node_ram #(
    .DEPTH (NODE_COUNT)
  ) u_node_ram (
    .clk   (clk),
    .we    (mem_we),
    .waddr (item.node_index[ADDR_W-1:0]),
    .wdata ({item.one_child_is_node, item.one_child_value,
             item.zero_child_is_node, item.zero_child_value}),
    .raddr (current_node_next[ADDR_W-1:0]),
    .rdata (node_rd)
  );

  // current bit picks one child of the node just read
  assign path      = data_byte[bit_cnt[2:0]];
  assign child     = path ? node_rd.one : node_rd.zero;
  assign bytes_inc = bytes_produced + LENGTH_BITS'(1);
  // byte done, stream over, or length already reached (also after a rewrite)
  assign stop      = bit_cnt[3] || stream_finished || (bytes_produced >= output_length);

  always_comb begin
    state_next           = state;
    current_node_next    = current_node;
    bytes_produced_next  = bytes_produced;
    stream_finished_next = stream_finished;
    bit_cnt_next         = bit_cnt;
    pend_valid_next      = pend_valid;
    pend_next            = pend;
    out_load             = 1'b0;
    out_load_data        = pend;
    mem_we               = 1'b0;
    data_load            = 1'b0;

    case (state)
      ST_IDLE: begin
        if (item_acc) begin
          case (item.kind)
            KIND_LOAD: begin
              // loads past the table are dropped
              mem_we = ({1'b0, item.node_index} < 9'(NODE_COUNT));
            end
            KIND_DATA: begin
              data_load    = 1'b1;
              bit_cnt_next = '0;
              state_next   = ST_WALK;
            end
            KIND_START: begin
              current_node_next    = ROOT;
              bytes_produced_next  = '0;
              stream_finished_next = 1'b0;
            end
            default: begin
            end
          endcase
        end
      end

      ST_WALK: begin
        if (stop) begin
          // flush the held result as the last of this run
          if (pend_valid) begin
            if (out_free) begin
              out_load               = 1'b1;
              out_load_data.run_last = 1'b1;
              pend_valid_next        = 1'b0;
              state_next             = ST_IDLE;
            end
          end else begin
            state_next = ST_IDLE;
          end
        end else if (child.is_node) begin
          // bad child index falls back to the root without output
          current_node_next = ({1'b0, child.value} < 9'(NODE_COUNT)) ? child.value : ROOT;
          bit_cnt_next      = bit_cnt + 4'd1;
        end else if (!pend_valid || out_free) begin
          // leaf: older pending result leaves, this one is held
          if (pend_valid) begin
            out_load = 1'b1;
          end
          pend_valid_next      = 1'b1;
          pend_next.out_byte   = child.value;
          pend_next.run_last   = 1'b0;
          pend_next.stream_end = (bytes_inc == output_length);
          stream_finished_next = (bytes_inc == output_length);
          bytes_produced_next  = bytes_inc;
          current_node_next    = ROOT;
          bit_cnt_next         = bit_cnt + 4'd1;
        end
        // else leaf waits for room on the result side
      end

      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state           <= ST_IDLE;
      current_node    <= ROOT;
      bytes_produced  <= '0;
      stream_finished <= 1'b0;
      bit_cnt         <= '0;
      pend_valid      <= 1'b0;
      result_valid    <= 1'b0;
      output_length   <= '0;
    end else begin
      state           <= state_next;
      current_node    <= current_node_next;
      bytes_produced  <= bytes_produced_next;
      stream_finished <= stream_finished_next;
      bit_cnt         <= bit_cnt_next;
      pend_valid      <= pend_valid_next;
      if (out_load) begin
        result_valid <= 1'b1;
      end else if (!result_stall) begin
        result_valid <= 1'b0;
      end
      if (cfg_valid && cfg_ready) begin
        output_length <= cfg_data;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    pend <= pend_next;
    if (out_load) begin
      result <= out_load_data;
    end
    if (data_load) begin
      data_byte <= item.compressed_byte;
    end
  end

  // nothing is left pending once the walk is back in idle
  assert property (@(posedge clk) disable iff (rst)
    (state == ST_IDLE) |-> !pend_valid)
    else $error("pending result left behind in idle");

  // the walk never sits on a node outside the table
  assert property (@(posedge clk) disable iff (rst)
    ({1'b0, current_node} < 9'(NODE_COUNT)))
    else $error("current node out of range");

  // a finished stream produces no more bytes until a new start
  assert property (@(posedge clk) disable iff (rst)
    (stream_finished && !(item_acc && item.kind == KIND_START))
      |=> (bytes_produced == $past(bytes_produced)))
    else $error("byte count moved after stream end");

endmodule

// File: rtl/core/htbd_node_ram.sv
// node table memory, one write port and one registered read port
module htbd_node_ram import htbd_pkg::*; #(
  parameter int DEPTH = 255
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  node_t                    wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output node_t                    rdata
);

  node_t mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule
